// ===== hw/rtl/nirt_pkg.sv =====
// Shared types and constants for the NEC-style IR frame transmitter.
// No dependencies; used by every module under hw/rtl.
`default_nettype none

package nirt_pkg;

  typedef enum logic [2:0] {
    PH_IDLE       = 3'd0,
    PH_LEAD_PULSE = 3'd1,
    PH_LEAD_SPACE = 3'd2,
    PH_BIT_PULSE  = 3'd3,
    PH_BIT_SPACE  = 3'd4,
    PH_STOP_PULSE = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    CFG_LEADER_PULSE = 2'd0,
    CFG_LEADER_SPACE = 2'd1,
    CFG_STOP_PULSE   = 2'd2,
    CFG_CARRIER_HALF = 2'd3
  } cfg_idx_t;

  localparam logic [15:0] BIT_PULSE_TICKS  = 16'd560;
  localparam logic [15:0] ONE_SPACE_TICKS  = 16'd1690;
  localparam logic [15:0] ZERO_SPACE_TICKS = 16'd560;
  localparam logic [5:0]  FRAME_BITS       = 6'd32;

  localparam logic [15:0] LEADER_PULSE_RST = 16'd9000;
  localparam logic [15:0] LEADER_SPACE_RST = 16'd4500;
  localparam logic [15:0] STOP_PULSE_RST   = 16'd560;
  localparam logic [7:0]  CARRIER_HALF_RST = 8'd12;

  typedef struct packed {
    logic [15:0] leader_pulse_ticks;
    logic [15:0] leader_space_ticks;
    logic [15:0] stop_pulse_ticks;
    logic [7:0]  carrier_half_ticks;
  } cfg_t;

  typedef struct packed {
    logic ir_level;
    logic busy_res;
    logic frame_done;
    logic start_rejected;
  } result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/nirt_core.sv =====
// Frame sequencer: phase, shift word, bit and segment counters, carrier.
// Depends on nirt_pkg; one state update and one result per accepted item.
`default_nettype none

module nirt_core (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    item_fire,
  input  wire                    item_cmd,
  input  wire  [15:0]            item_address_word,
  input  wire  [15:0]            item_command_code,
  input  nirt_pkg::cfg_t         cfg,
  output nirt_pkg::result_t      res
);

  nirt_pkg::phase_t phase_r, phase_nxt, ent_ph;
  logic [31:0] shift_r, shift_nxt;
  logic [5:0]  bits_left_r, bits_left_nxt, bits_dec;
  logic [15:0] seg_r, seg_nxt, seg_dec, seg_len;
  logic [7:0]  car_cnt_r, car_cnt_nxt, car_dec, half;
  logic        car_lvl_r, car_lvl_nxt;
  logic        enter;

  always_comb begin
    res           = '0;
    phase_nxt     = phase_r;
    shift_nxt     = shift_r;
    bits_left_nxt = bits_left_r;
    seg_nxt       = seg_r;
    car_cnt_nxt   = car_cnt_r;
    car_lvl_nxt   = car_lvl_r;
    enter         = 1'b0;
    ent_ph        = nirt_pkg::PH_IDLE;
    seg_len       = 16'd0;
    seg_dec       = seg_r - 16'd1;
    car_dec       = car_cnt_r - 8'd1;
    bits_dec      = bits_left_r - 6'd1;
    half          = (cfg.carrier_half_ticks == 8'd0) ? 8'd1 : cfg.carrier_half_ticks;

    if (item_cmd) begin
      res.busy_res = 1'b1;
      if (phase_r != nirt_pkg::PH_IDLE) begin
        res.start_rejected = 1'b1;
      end else begin
        shift_nxt     = {item_address_word, item_command_code};
        bits_left_nxt = nirt_pkg::FRAME_BITS;
        enter         = 1'b1;
        if (cfg.leader_pulse_ticks != 16'd0) begin
          ent_ph = nirt_pkg::PH_LEAD_PULSE;
        end else if (cfg.leader_space_ticks != 16'd0) begin
          ent_ph = nirt_pkg::PH_LEAD_SPACE;
        end else begin
          ent_ph = nirt_pkg::PH_BIT_PULSE;
        end
      end
    end else if (phase_r != nirt_pkg::PH_IDLE) begin
      res.busy_res = 1'b1;
      if (phase_r inside {nirt_pkg::PH_LEAD_PULSE, nirt_pkg::PH_BIT_PULSE,
                          nirt_pkg::PH_STOP_PULSE}) begin
        res.ir_level = car_lvl_r;
        if (car_dec == 8'd0) begin
          car_lvl_nxt = ~car_lvl_r;
          car_cnt_nxt = half;
        end else begin
          car_cnt_nxt = car_dec;
        end
      end
      seg_nxt = seg_dec;
      if (seg_dec == 16'd0) begin
        enter = 1'b1;
        case (phase_r)
          nirt_pkg::PH_LEAD_PULSE: begin
            ent_ph = (cfg.leader_space_ticks != 16'd0) ? nirt_pkg::PH_LEAD_SPACE
                                                       : nirt_pkg::PH_BIT_PULSE;
          end
          nirt_pkg::PH_LEAD_SPACE: ent_ph = nirt_pkg::PH_BIT_PULSE;
          nirt_pkg::PH_BIT_PULSE:  ent_ph = nirt_pkg::PH_BIT_SPACE;
          nirt_pkg::PH_BIT_SPACE: begin
            shift_nxt     = {shift_r[30:0], 1'b0};
            bits_left_nxt = bits_dec;
            if (bits_dec != 6'd0) begin
              ent_ph = nirt_pkg::PH_BIT_PULSE;
            end else if (cfg.stop_pulse_ticks != 16'd0) begin
              ent_ph = nirt_pkg::PH_STOP_PULSE;
            end else begin
              ent_ph = nirt_pkg::PH_IDLE;
            end
          end
          default: ent_ph = nirt_pkg::PH_IDLE;
        endcase
        res.frame_done = (ent_ph == nirt_pkg::PH_IDLE);
      end
    end

    if (enter) begin
      case (ent_ph)
        nirt_pkg::PH_LEAD_PULSE: seg_len = cfg.leader_pulse_ticks;
        nirt_pkg::PH_LEAD_SPACE: seg_len = cfg.leader_space_ticks;
        nirt_pkg::PH_BIT_PULSE:  seg_len = nirt_pkg::BIT_PULSE_TICKS;
        nirt_pkg::PH_BIT_SPACE: begin
          seg_len = shift_nxt[31] ? nirt_pkg::ONE_SPACE_TICKS : nirt_pkg::ZERO_SPACE_TICKS;
        end
        nirt_pkg::PH_STOP_PULSE: seg_len = cfg.stop_pulse_ticks;
        default:                 seg_len = 16'd0;
      endcase
      phase_nxt = ent_ph;
      seg_nxt   = seg_len;
      if (ent_ph inside {nirt_pkg::PH_LEAD_PULSE, nirt_pkg::PH_BIT_PULSE,
                         nirt_pkg::PH_STOP_PULSE}) begin
        car_lvl_nxt = 1'b1;
        car_cnt_nxt = half;
      end else begin
        car_lvl_nxt = 1'b0;
        car_cnt_nxt = 8'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= nirt_pkg::PH_IDLE;
      shift_r     <= '0;
      bits_left_r <= '0;
      seg_r       <= '0;
      car_cnt_r   <= '0;
      car_lvl_r   <= 1'b0;
    end else if (item_fire) begin
      phase_r     <= phase_nxt;
      shift_r     <= shift_nxt;
      bits_left_r <= bits_left_nxt;
      seg_r       <= seg_nxt;
      car_cnt_r   <= car_cnt_nxt;
      car_lvl_r   <= car_lvl_nxt;
    end
  end

  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == nirt_pkg::PH_IDLE) |-> (seg_r == 16'd0 && car_lvl_r == 1'b0 &&
                                        car_cnt_r == 8'd0))
    else $error("idle with live counters");

  a_busy_seg: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != nirt_pkg::PH_IDLE) |-> (seg_r != 16'd0))
    else $error("active segment with zero count");

  a_space_dark: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == nirt_pkg::PH_LEAD_SPACE || phase_r == nirt_pkg::PH_BIT_SPACE)
    |-> (car_lvl_r == 1'b0 && car_cnt_r == 8'd0))
    else $error("carrier running in a space");

  a_burst_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == nirt_pkg::PH_LEAD_PULSE || phase_r == nirt_pkg::PH_BIT_PULSE ||
     phase_r == nirt_pkg::PH_STOP_PULSE) |-> (car_cnt_r != 8'd0))
    else $error("burst with zero carrier count");

  a_bits: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == nirt_pkg::PH_BIT_PULSE || phase_r == nirt_pkg::PH_BIT_SPACE)
    |-> (bits_left_r != 6'd0 && bits_left_r <= nirt_pkg::FRAME_BITS))
    else $error("bit phase with bad bit count");

endmodule

`default_nettype wire

// ===== hw/rtl/nirt_out_skid.sv =====
// Result register with one skid entry between the sequencer and out_ channel.
// Depends on nirt_pkg for the result type.
`default_nettype none

module nirt_out_skid (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    push,
  input  nirt_pkg::result_t      push_data,
  output logic                   full,
  output logic                   out_valid,
  input  wire                    out_stall,
  output nirt_pkg::result_t      out_data
);

  logic              out_valid_r, skid_valid_r;
  nirt_pkg::result_t out_data_r, skid_data_r;
  logic              out_open;

  assign out_open  = !out_valid_r || !out_stall;
  assign full      = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_open) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r  <= push;
      end
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_open) begin
      out_data_r <= skid_valid_r ? skid_data_r : push_data;
    end else if (push) begin
      skid_data_r <= push_data;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/nec_ir_frame_transmitter.sv =====
// NEC-style IR frame transmitter, one result per tick or start item.
// Takes one item every clock while in_stall is low; in_stall rises only while
// a result sits in the skid entry because out_stall held the output register.
// Results reach out_ via the output register or the skid entry. Registers
// reset to leader burst 9000, leader space 4500, stop burst 560 and carrier
// half period 12 ticks; cfg_ready is always high.
// Depends on nirt_pkg, nirt_core and nirt_out_skid.
`default_nettype none

module nec_ir_frame_transmitter (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire         in_cmd,
  input  wire  [15:0] in_address_word,
  input  wire  [15:0] in_command_code,
  output logic        out_valid,
  input  wire         out_stall,
  output logic        out_ir_level,
  output logic        out_busy_res,
  output logic        out_frame_done,
  output logic        out_start_rejected,
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [1:0]  cfg_index,
  input  wire  [15:0] cfg_data
);

  nirt_pkg::cfg_t    cfg_r;
  nirt_pkg::result_t res, out_res;
  logic              full, in_fire;

  assign cfg_ready = 1'b1;
  assign in_stall  = full;
  assign in_fire   = in_valid && !full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.leader_pulse_ticks <= nirt_pkg::LEADER_PULSE_RST;
      cfg_r.leader_space_ticks <= nirt_pkg::LEADER_SPACE_RST;
      cfg_r.stop_pulse_ticks   <= nirt_pkg::STOP_PULSE_RST;
      cfg_r.carrier_half_ticks <= nirt_pkg::CARRIER_HALF_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (nirt_pkg::cfg_idx_t'(cfg_index))
        nirt_pkg::CFG_LEADER_PULSE: cfg_r.leader_pulse_ticks <= cfg_data;
        nirt_pkg::CFG_LEADER_SPACE: cfg_r.leader_space_ticks <= cfg_data;
        nirt_pkg::CFG_STOP_PULSE:   cfg_r.stop_pulse_ticks   <= cfg_data;
        nirt_pkg::CFG_CARRIER_HALF: cfg_r.carrier_half_ticks <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  nirt_core u_core (
    .clk               (clk),
    .rst_n             (rst_n),
    .item_fire         (in_fire),
    .item_cmd          (in_cmd),
    .item_address_word (in_address_word),
    .item_command_code (in_command_code),
    .cfg               (cfg_r),
    .res               (res)
  );

  nirt_out_skid u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_fire),
    .push_data (res),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_res)
  );

  assign out_ir_level       = out_res.ir_level;
  assign out_busy_res       = out_res.busy_res;
  assign out_frame_done     = out_res.frame_done;
  assign out_start_rejected = out_res.start_rejected;

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for nec_ir_frame_transmitter: drives tick and start transfers
// and checks every result against a frame predictor kept in this file.
// Depends on nirt_pkg and the transmitter RTL.

module testbench;

  localparam int CYCLE_LIMIT = 4000000;
  localparam int PHASE_ITEMS = 300;
  localparam bit CMD_TICK  = 1'b0;
  localparam bit CMD_START = 1'b1;

  typedef struct {
    bit        cmd;
    bit [15:0] address_word;
    bit [15:0] command_code;
  } ir_item_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_cmd = CMD_TICK;
  logic [15:0] in_address_word = '0;
  logic [15:0] in_command_code = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_ir_level;
  logic        out_busy_res;
  logic        out_frame_done;
  logic        out_start_rejected;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = nirt_pkg::CFG_LEADER_PULSE;
  logic [15:0] cfg_data = '0;

  nec_ir_frame_transmitter dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_cmd             (in_cmd),
    .in_address_word    (in_address_word),
    .in_command_code    (in_command_code),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_ir_level       (out_ir_level),
    .out_busy_res       (out_busy_res),
    .out_frame_done     (out_frame_done),
    .out_start_rejected (out_start_rejected),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  // frame predictor state
  nirt_pkg::cfg_t   tx_cfg;
  nirt_pkg::phase_t tx_phase;
  logic [31:0]      tx_word;
  logic [5:0]       tx_bits_left;
  logic [15:0]      tx_segment;
  logic [7:0]       tx_carrier_count;
  logic             tx_carrier_level;

  ir_item_t          feed_queue[$];
  nirt_pkg::result_t ir_results_due[$];
  ir_item_t          driven_item;
  nirt_pkg::result_t seen;
  nirt_pkg::result_t want;

  int items_left = 0;
  int fail_count = 0;
  int results_seen = 0;
  int cycle_count = 0;
  int gap_left = 0;
  int stall_left = 0;
  bit calm = 1'b0;
  bit pressure_done = 1'b0;

  function automatic logic [7:0] carrier_reload();
    return (tx_cfg.carrier_half_ticks == 8'd0) ? 8'd1 : tx_cfg.carrier_half_ticks;
  endfunction

  function automatic bit in_burst(nirt_pkg::phase_t p);
    return p == nirt_pkg::PH_LEAD_PULSE || p == nirt_pkg::PH_BIT_PULSE ||
           p == nirt_pkg::PH_STOP_PULSE;
  endfunction

  // leaving a bit space consumes that bit
  function automatic nirt_pkg::phase_t segment_after(nirt_pkg::phase_t p);
    case (p)
      nirt_pkg::PH_LEAD_PULSE: return nirt_pkg::PH_LEAD_SPACE;
      nirt_pkg::PH_LEAD_SPACE: return nirt_pkg::PH_BIT_PULSE;
      nirt_pkg::PH_BIT_PULSE:  return nirt_pkg::PH_BIT_SPACE;
      nirt_pkg::PH_BIT_SPACE: begin
        tx_word = tx_word << 1;
        tx_bits_left = tx_bits_left - 6'd1;
        return (tx_bits_left != 6'd0) ? nirt_pkg::PH_BIT_PULSE : nirt_pkg::PH_STOP_PULSE;
      end
      default: return nirt_pkg::PH_IDLE;
    endcase
  endfunction

  // skip segments of zero length
  function automatic void enter_segment(nirt_pkg::phase_t first);
    nirt_pkg::phase_t p;
    logic [15:0]      len;
    bit               settled;
    p = first;
    settled = 1'b0;
    while (!settled) begin
      len = '0;
      case (p)
        nirt_pkg::PH_LEAD_PULSE: len = tx_cfg.leader_pulse_ticks;
        nirt_pkg::PH_LEAD_SPACE: len = tx_cfg.leader_space_ticks;
        nirt_pkg::PH_BIT_PULSE:  len = nirt_pkg::BIT_PULSE_TICKS;
        nirt_pkg::PH_BIT_SPACE: begin
          len = tx_word[31] ? nirt_pkg::ONE_SPACE_TICKS : nirt_pkg::ZERO_SPACE_TICKS;
        end
        nirt_pkg::PH_STOP_PULSE: len = tx_cfg.stop_pulse_ticks;
        default: begin
          tx_phase = nirt_pkg::PH_IDLE;
          tx_segment = '0;
          tx_carrier_count = '0;
          tx_carrier_level = 1'b0;
          settled = 1'b1;
        end
      endcase
      if (!settled) begin
        if (len != 16'd0) begin
          tx_phase = p;
          tx_segment = len;
          tx_carrier_level = in_burst(p);
          tx_carrier_count = in_burst(p) ? carrier_reload() : 8'd0;
          settled = 1'b1;
        end else begin
          p = segment_after(p);
        end
      end
    end
  endfunction

  function automatic nirt_pkg::result_t predict_ir_tick(bit cmd, logic [15:0] addr,
                                                         logic [15:0] code);
    nirt_pkg::result_t r;
    r = '0;
    if (cmd == CMD_START) begin
      r.busy_res = 1'b1;
      if (tx_phase != nirt_pkg::PH_IDLE) begin
        r.start_rejected = 1'b1;
      end else begin
        tx_word = {addr, code};
        tx_bits_left = nirt_pkg::FRAME_BITS;
        enter_segment(nirt_pkg::PH_LEAD_PULSE);
      end
    end else if (tx_phase != nirt_pkg::PH_IDLE) begin
      r.busy_res = 1'b1;
      if (in_burst(tx_phase)) begin
        r.ir_level = tx_carrier_level;
        tx_carrier_count = tx_carrier_count - 8'd1;
        if (tx_carrier_count == 8'd0) begin
          tx_carrier_level = ~tx_carrier_level;
          tx_carrier_count = carrier_reload();
        end
      end
      tx_segment = tx_segment - 16'd1;
      if (tx_segment == 16'd0) begin
        enter_segment(segment_after(tx_phase));
        r.frame_done = (tx_phase == nirt_pkg::PH_IDLE);
      end
    end
    return r;
  endfunction

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        ir_results_due.push_back(predict_ir_tick(in_cmd, in_address_word, in_command_code));
        items_left--;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
          gap_left = $urandom_range(0, 9);
          in_valid <= 1'b0;
        end else if (feed_queue.size() != 0) begin
          driven_item = feed_queue.pop_front();
          in_cmd <= driven_item.cmd;
          in_address_word <= driven_item.address_word;
          in_command_code <= driven_item.command_code;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor and receiver stall
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        seen = {out_ir_level, out_busy_res, out_frame_done, out_start_rejected};
        if (ir_results_due.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("result %0d arrived with none pending: level %b busy %b done %b rejected %b",
                     results_seen, seen.ir_level, seen.busy_res, seen.frame_done,
                     seen.start_rejected);
        end else begin
          want = ir_results_due.pop_front();
          if (seen.ir_level !== want.ir_level || seen.busy_res !== want.busy_res ||
              seen.frame_done !== want.frame_done ||
              seen.start_rejected !== want.start_rejected) begin
            fail_count++;
            if (fail_count <= 10)
              $display("result %0d: expected level %b busy %b done %b rejected %b, %s %b %b %b %b",
                       results_seen, want.ir_level, want.busy_res, want.frame_done,
                       want.start_rejected, "got", seen.ir_level, seen.busy_res,
                       seen.frame_done, seen.start_rejected);
          end
        end
        results_seen++;
      end
      if (stall_left != 0) begin
        stall_left--;
      end else if (!pressure_done && results_seen >= 400) begin
        pressure_done = 1'b1;
        stall_left = 400;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 10);
      end
      out_stall <= (stall_left != 0);
    end
  end

  task automatic push_item(bit cmd, logic [15:0] addr, logic [15:0] code);
    ir_item_t it;
    it.cmd = cmd;
    it.address_word = addr;
    it.command_code = code;
    feed_queue.push_back(it);
    items_left++;
  endtask

  task automatic wait_quiet();
    do @(posedge clk); while (items_left != 0 || ir_results_due.size() != 0);
  endtask

  task automatic write_reg(nirt_pkg::cfg_idx_t idx, logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      nirt_pkg::CFG_LEADER_PULSE: tx_cfg.leader_pulse_ticks = data;
      nirt_pkg::CFG_LEADER_SPACE: tx_cfg.leader_space_ticks = data;
      nirt_pkg::CFG_STOP_PULSE:   tx_cfg.stop_pulse_ticks = data;
      nirt_pkg::CFG_CARRIER_HALF: tx_cfg.carrier_half_ticks = data[7:0];
      default: ;
    endcase
  endtask

  // call only while nothing is in flight
  task automatic write_regs(logic [15:0] lead_pulse, logic [15:0] lead_space,
                            logic [15:0] stop_pulse, logic [15:0] carrier_half);
    write_reg(nirt_pkg::CFG_LEADER_PULSE, lead_pulse);
    write_reg(nirt_pkg::CFG_LEADER_SPACE, lead_space);
    write_reg(nirt_pkg::CFG_STOP_PULSE, stop_pulse);
    write_reg(nirt_pkg::CFG_CARRIER_HALF, carrier_half);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [15:0] short_ticks();
    return ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom_range(1, 60));
  endfunction

  function automatic logic [15:0] short_carrier();
    return {8'($urandom_range(0, 255)), 8'($urandom_range(0, 6))};
  endfunction

  initial begin
    tx_cfg = '{nirt_pkg::LEADER_PULSE_RST, nirt_pkg::LEADER_SPACE_RST,
               nirt_pkg::STOP_PULSE_RST, nirt_pkg::CARRIER_HALF_RST};
    tx_phase = nirt_pkg::PH_IDLE;
    tx_word = '0;
    tx_bits_left = '0;
    tx_segment = '0;
    tx_carrier_count = '0;
    tx_carrier_level = 1'b0;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // short leader with its space skipped; the ticks below end inside the leader burst
    write_regs(16'd40, 16'd0, 16'd2, 16'd3);

    push_item(CMD_TICK, 16'hFFFF, 16'hFFFF);
    push_item(CMD_START, 16'hFFFF, 16'h0000);
    push_item(CMD_START, 16'h0000, 16'hFFFF);
    repeat (20) push_item(CMD_TICK, 16'h0000, 16'h0000);
    wait_quiet();

    for (int r = 0; r < 6; r++) begin
      calm = (r == 2 || r == 5);
      if (r == 0)
        write_regs(16'd0, 16'd0, 16'd0, 16'd0);
      else if (r == 1)
        write_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      else
        write_regs(short_ticks(), short_ticks(), short_ticks(), short_carrier());
      push_item(CMD_START, 16'($urandom), 16'($urandom));
      repeat (PHASE_ITEMS) begin
        if ($urandom_range(0, 11) == 0)
          push_item(CMD_START, 16'($urandom), 16'($urandom));
        else
          push_item(CMD_TICK, 16'($urandom), 16'($urandom));
      end
      wait_quiet();
    end

    repeat (20) @(posedge clk);
    if (fail_count == 0 && ir_results_due.size() == 0)
      $display("testbench OK");
    else
      $display("testbench NOT OK");
    $finish;
  end

endmodule
